// ===== hdl/assert_macros.svh =====
// Assertion helpers on clk_i / rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BFPU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

`define BFPU_ASSERT_CLK(lbl, prop) `BFPU_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ===== hdl/bfpu_pkg.sv =====
package bfpu_pkg;

  parameter int unsigned BUF_BYTES_DEF  = 1024;
  parameter int unsigned FIELD_BITS_DEF = 32;

  parameter logic [2:0] FN_FIELD  = 3'd0;
  parameter logic [2:0] FN_ALIGN  = 3'd1;
  parameter logic [2:0] FN_RAW    = 3'd2;
  parameter logic [2:0] FN_REWIND = 3'd3;
  parameter logic [2:0] FN_HWR    = 3'd4;
  parameter logic [2:0] FN_HRD    = 3'd5;

  parameter logic [1:0] ST_OK    = 2'd0;
  parameter logic [1:0] ST_TRUNC = 2'd1;
  parameter logic [1:0] ST_RANGE = 2'd2;

  parameter logic [3:0] CFG_READ_MODE = 4'd0;
  parameter logic [3:0] CFG_BIT_SIZE  = 4'd1;

  parameter logic [13:0] BIT_SIZE_RST = 14'd8192;

endpackage

// ===== hdl/bit_field_pack_unpack_core.sv =====
// MSB-first bit packer / unpacker over a byte buffer with a bit cursor.
// Input channel (in_valid_i / in_ready_o) carries one operation item:
// func_i selects field, align, raw byte, rewind, host write or host read.
// Output channel (out_valid_o / out_ready_i) returns one result item per
// input item: value, bits moved, status and cursor position afterwards.
// Config port: cfg_we_i writes read_mode (index 0) or data_bit_size
// (index 1); write only while no item is in flight.
// Items are handled one at a time by a sequencer around a single-port
// buffer RAM (one byte access per cycle, registered read data).
// Each item passes S_WID (field width from the range, value less range_min),
// then S_HMOD for host access (host address reduced modulo the buffer
// size), then S_PREP; buffer reads run S_RD and S_RDL, writes run S_WR
// (after a read of the first byte if the field starts mid-byte), reads end
// in S_FIN, and every item ends in S_DONE, which loads the result register.
// Reset: cursor and control registers reset (data_bit_size to 8192), then
// the buffer is zeroed one byte per cycle with in_ready_o low.
// A stalled receiver holds the result in the output register; the next
// item is accepted meanwhile and waits at completion for the register.
module bit_field_pack_unpack_core #(
  parameter int unsigned BUF_BYTES  = bfpu_pkg::BUF_BYTES_DEF,
  parameter int unsigned FIELD_BITS = bfpu_pkg::FIELD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] value_in_i,
  input  logic [31:0] range_min_i,
  input  logic [31:0] range_max_i,
  input  logic [9:0]  host_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_out_o,
  output logic [5:0]  width_used_o,
  output logic [1:0]  status_o,
  output logic [13:0] cursor_bits_o
);

  localparam int unsigned AW    = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
  localparam int unsigned CAP   = BUF_BYTES * 8;
  localparam int unsigned MOD_K = (BUF_BYTES >= 1024) ? 0 : $clog2(1024 / BUF_BYTES);
  localparam int unsigned MKW   = $clog2(MOD_K + 2);
  localparam logic [14:0] LIM_CAP = (CAP > 16383) ? 15'd16383 : 15'(CAP);
  localparam logic [AW-1:0] LAST  = AW'(BUF_BYTES - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WID, S_HMOD, S_PREP, S_RD, S_RDL, S_WR, S_FIN, S_DONE
  } state_e;

  function automatic logic [5:0] bitlen(input logic [31:0] x);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic            mode_q;
  logic [13:0]     dbs_q;
  logic [2:0]      func_q;
  logic [31:0]     vin_q, rmin_q, rmax_q;
  logic [9:0]      haddr_q, r_q;
  logic [MKW-1:0]  mk_q;
  logic [5:0]      w_q, sh_q, mw_q, used_q;
  logic [31:0]     v_q, raw_q;
  logic [14:0]     pos_q;
  logic [AW-1:0]   base_q;
  logic [2:0]      nb_q, rdn_q, k_q;
  logic [39:0]     wwin_q, win_q;
  logic [7:0]      old_q, rdata_q;
  logic            rdp_q, is_rd_q, pack_q;
  logic [1:0]      stat_q;
  logic            out_valid_q;
  logic [31:0]     vout_q;
  logic [5:0]      uout_q;
  logic [1:0]      sout_q;
  logic [13:0]     cout_q;

  logic [7:0]      mem_q [BUF_BYTES];
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [7:0]      mem_wdata;

  // prep-stage values and write-byte merge
  logic [2:0]  off;
  logic [14:0] limit, avail, aligned;
  logic [5:0]  n_pk;
  logic        trunc, over, raw_ok;
  logic [63:0] bits_n;
  logic [5:0]  wsh;
  logic [39:0] wwin_pk;
  logic [6:0]  sum_pk, sum_un;
  logic [2:0]  nb_pk, nb_un;
  logic [31:0] pb32, ab32, hb32;
  logic [5:0]  shw;
  logic [39:0] wshift;
  logic [7:0]  wbyte;

  always_comb begin
    off     = pos_q[2:0];
    limit   = (32'(dbs_q) < CAP) ? {1'b0, dbs_q} : LIM_CAP;
    avail   = (pos_q < limit) ? (limit - pos_q) : 15'd0;
    trunc   = {9'd0, w_q} > avail;
    n_pk    = trunc ? avail[5:0] : w_q;
    bits_n  = (64'(v_q) >> (w_q - n_pk)) & ((64'd1 << n_pk) - 64'd1);
    wsh     = 6'd40 - {3'd0, off} - n_pk;
    wwin_pk = 40'(bits_n << wsh);
    sum_pk  = 7'(off) + 7'(n_pk) + 7'd7;
    nb_pk   = sum_pk[5:3];
    sum_un  = 7'(off) + 7'(w_q) + 7'd7;
    nb_un   = sum_un[5:3];
    over    = (16'(pos_q) + 16'(w_q)) > 16'(limit);
    aligned = (off != 3'd0) ? {pos_q[14:3] + 12'd1, 3'd0} : pos_q;
    raw_ok  = (16'(aligned) + 16'd8) <= 16'(limit);
    pb32    = 32'(pos_q[14:3]);
    ab32    = 32'(aligned[14:3]);
    hb32    = 32'(r_q);
    shw     = 6'd32 - {k_q, 3'd0};
    wshift  = wwin_q >> shw;
    wbyte   = wshift[7:0] | ((k_q == 3'd0) ? old_q : 8'd0);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = base_q + AW'(k_q);
    mem_wdata = wbyte;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = 8'd0;
      end
      S_WR:    mem_we = 1'b1;
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      dbs_q  <= bfpu_pkg::BIT_SIZE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bfpu_pkg::CFG_READ_MODE) mode_q <= cfg_wdata_i[0];
      if (cfg_idx_i == bfpu_pkg::CFG_BIT_SIZE)  dbs_q  <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      pos_q       <= '0;
      rdp_q       <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (rdp_q) begin
        win_q <= {win_q[31:0], rdata_q};
        old_q <= rdata_q;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LAST) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            func_q  <= func_i;
            vin_q   <= value_in_i;
            rmin_q  <= range_min_i;
            rmax_q  <= range_max_i;
            haddr_q <= host_addr_i;
            state_q <= S_WID;
          end
        end
        S_WID: begin
          w_q <= (bitlen(rmax_q - rmin_q) > 6'(FIELD_BITS)) ? 6'(FIELD_BITS)
                                                           : bitlen(rmax_q - rmin_q);
          v_q  <= vin_q - rmin_q;
          r_q  <= haddr_q;
          mk_q <= MKW'(MOD_K);
          if (func_q == bfpu_pkg::FN_HWR || func_q == bfpu_pkg::FN_HRD) begin
            state_q <= S_HMOD;
          end else begin
            state_q <= S_PREP;
          end
        end
        S_HMOD: begin
          if (32'(r_q) >= (32'(BUF_BYTES) << mk_q)) begin
            r_q <= r_q - 10'(32'(BUF_BYTES) << mk_q);
          end
          mk_q <= mk_q - MKW'(1);
          if (mk_q == '0) state_q <= S_PREP;
        end
        S_PREP: begin
          stat_q  <= bfpu_pkg::ST_OK;
          used_q  <= 6'd0;
          is_rd_q <= 1'b0;
          pack_q  <= 1'b0;
          win_q   <= '0;
          old_q   <= 8'd0;
          k_q     <= '0;
          nb_q    <= 3'd1;
          rdn_q   <= 3'd1;
          sh_q    <= 6'd0;
          mw_q    <= 6'd8;
          wwin_q  <= {vin_q[7:0], 32'd0};
          base_q  <= ab32[AW-1:0];
          state_q <= S_DONE;
          case (func_q)
            bfpu_pkg::FN_FIELD: begin
              base_q <= pb32[AW-1:0];
              if (!mode_q) begin
                pack_q <= 1'b1;
                stat_q <= trunc ? bfpu_pkg::ST_TRUNC : bfpu_pkg::ST_OK;
                used_q <= n_pk;
                pos_q  <= pos_q + 15'(n_pk);
                wwin_q <= wwin_pk;
                nb_q   <= nb_pk;
                if (n_pk == 6'd0) state_q <= S_DONE;
                else if (off != 3'd0) state_q <= S_RD;
                else state_q <= S_WR;
              end else if (over) begin
                stat_q <= bfpu_pkg::ST_RANGE;
              end else begin
                is_rd_q <= 1'b1;
                used_q  <= w_q;
                pos_q   <= pos_q + 15'(w_q);
                rdn_q   <= nb_un;
                mw_q    <= w_q;
                sh_q    <= 6'({nb_un, 3'd0}) - 6'(off) - w_q;
                state_q <= (nb_un == 3'd0) ? S_FIN : S_RD;
              end
            end
            bfpu_pkg::FN_ALIGN: pos_q <= aligned;
            bfpu_pkg::FN_RAW: begin
              pos_q <= aligned;
              if (!raw_ok) begin
                stat_q <= bfpu_pkg::ST_RANGE;
              end else begin
                used_q <= 6'd8;
                pos_q  <= aligned + 15'd8;
                if (mode_q) begin
                  is_rd_q <= 1'b1;
                  rmin_q  <= 32'd0;
                  state_q <= S_RD;
                end else begin
                  state_q <= S_WR;
                end
              end
            end
            bfpu_pkg::FN_REWIND: pos_q <= '0;
            bfpu_pkg::FN_HWR: begin
              base_q  <= hb32[AW-1:0];
              state_q <= S_WR;
            end
            bfpu_pkg::FN_HRD: begin
              base_q  <= hb32[AW-1:0];
              is_rd_q <= 1'b1;
              rmin_q  <= 32'd0;
              state_q <= S_RD;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_RD: begin
          rdp_q <= 1'b1;
          k_q   <= k_q + 3'd1;
          if (k_q == rdn_q - 3'd1) begin
            k_q     <= '0;
            state_q <= S_RDL;
          end
        end
        S_RDL: begin
          rdp_q   <= 1'b0;
          state_q <= pack_q ? S_WR : S_FIN;
        end
        S_WR: begin
          k_q <= k_q + 3'd1;
          if (k_q == nb_q - 3'd1) state_q <= S_DONE;
        end
        S_FIN: begin
          raw_q   <= 32'((64'(win_q) >> sh_q) & ((64'd1 << mw_q) - 64'd1));
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            vout_q      <= is_rd_q ? (raw_q + rmin_q) : 32'd0;
            uout_q      <= used_q;
            sout_q      <= stat_q;
            cout_q      <= pos_q[13:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign value_out_o   = vout_q;
  assign width_used_o  = uout_q;
  assign status_o      = sout_q;
  assign cursor_bits_o = cout_q;

endmodule

// ===== hdl/bfpu_chk.sv =====
`include "assert_macros.svh"

module bfpu_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] value_out_o,
  input logic [5:0]  width_used_o,
  input logic [1:0]  status_o,
  input logic [13:0] cursor_bits_o
);

  `BFPU_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_out_o) && $stable(cursor_bits_o))
  `BFPU_ASSERT_CLK(a_status_code, out_valid_o |-> status_o == bfpu_pkg::ST_OK || status_o == bfpu_pkg::ST_TRUNC || status_o == bfpu_pkg::ST_RANGE)
  `BFPU_ASSERT_CLK(a_range_zero, out_valid_o && status_o == bfpu_pkg::ST_RANGE |-> value_out_o == 32'd0)
  `BFPU_ASSERT_CLK(a_width_max, out_valid_o |-> width_used_o <= 6'd32)

endmodule

bind bit_field_pack_unpack_core bfpu_chk u_bfpu_chk (.*);
